/* design/qcfw_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the quad corner forward warp.
package qcfw_pkg;

   localparam int unsigned SRC_W   = 6;   // source coordinate
   localparam int unsigned CRD_W   = 12;  // corner and destination coordinate
   localparam int unsigned PIX_W   = 16;  // pixel
   localparam int unsigned IDX_W   = 12;  // read index field
   localparam int unsigned CFG_IDX_W = 3;

   // Mapping datapath widths, sized for frames up to 256 x 256.
   localparam int unsigned FAC_W = 10;            // W-x, H-y, x, y
   localparam int unsigned P_W   = CRD_W + FAC_W; // corner times factor
   localparam int unsigned S_W   = P_W + 1;       // sum of two products
   localparam int unsigned M_W   = S_W + FAC_W;   // sum times factor
   localparam int unsigned NUM_W = M_W + 1;       // full numerator

   typedef enum logic [1:0] {
      REQ_CLEAR = 2'd0,
      REQ_PLACE = 2'd1,
      REQ_READ  = 2'd2,
      REQ_NOP   = 2'd3
   } req_code_type;

   typedef enum logic [CFG_IDX_W-1:0] {
      CFG_UL_X = 3'd0,
      CFG_UL_Y = 3'd1,
      CFG_UR_X = 3'd2,
      CFG_UR_Y = 3'd3,
      CFG_LR_X = 3'd4,
      CFG_LR_Y = 3'd5,
      CFG_LL_X = 3'd6,
      CFG_LL_Y = 3'd7
   } cfg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_MAP,
      ST_DIV,
      ST_WRITE,
      ST_READ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [CRD_W-1:0] ul_x;
      logic signed [CRD_W-1:0] ul_y;
      logic signed [CRD_W-1:0] ur_x;
      logic signed [CRD_W-1:0] ur_y;
      logic signed [CRD_W-1:0] lr_x;
      logic signed [CRD_W-1:0] lr_y;
      logic signed [CRD_W-1:0] ll_x;
      logic signed [CRD_W-1:0] ll_y;
   } corner_type;

   localparam corner_type CORNER_RESET = '{
      ul_x: 12'sd0,  ul_y: 12'sd0,
      ur_x: 12'sd64, ur_y: 12'sd0,
      lr_x: 12'sd64, lr_y: 12'sd64,
      ll_x: 12'sd0,  ll_y: 12'sd64
   };

   typedef struct packed {
      logic [1:0]       req_type;
      logic [SRC_W-1:0] src_x;
      logic [SRC_W-1:0] src_y;
      logic [PIX_W-1:0] src_pixel;
      logic [IDX_W-1:0] read_index;
   } req_word_type;

   typedef struct packed {
      logic signed [CRD_W-1:0] dest_x;
      logic signed [CRD_W-1:0] dest_y;
      logic                    placed;
      logic [PIX_W-1:0]        read_pixel;
   } rsp_word_type;

endpackage

/* design/qcfw_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read.
module qcfw_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/qcfw_map.sv */
`timescale 1ns / 1ps
// Four-stage bilinear numerator pipeline for the destination coordinates.
module qcfw_map import qcfw_pkg::*; #(
   parameter int unsigned IMG_W = 64,
   parameter int unsigned IMG_H = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [SRC_W-1:0]        src_x,
   input  logic [SRC_W-1:0]        src_y,
   input  corner_type              corners,
   output logic                    done,
   output logic signed [NUM_W-1:0] num_x,
   output logic signed [NUM_W-1:0] num_y
);

   logic signed [FAC_W-1:0] wmx, hmy, xs, ys;
   logic signed [FAC_W-1:0] wmx_ff, hmy_ff, xs_ff, ys_ff;
   logic [3:0] stage_ff, stage_in;
   logic signed [P_W-1:0] prod_ff [8];
   logic signed [S_W-1:0] sum_ff [4];
   logic signed [M_W-1:0] mul_ff [4];
   logic signed [NUM_W-1:0] num_x_ff, num_y_ff;

   assign wmx = FAC_W'(IMG_W) - FAC_W'(src_x);
   assign hmy = FAC_W'(IMG_H) - FAC_W'(src_y);
   assign xs  = FAC_W'(src_x);
   assign ys  = FAC_W'(src_y);

   assign stage_in = {stage_ff[2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      // corner times edge weight
      if (start) begin
         prod_ff[0] <= corners.ul_x * hmy;
         prod_ff[1] <= corners.ll_x * ys;
         prod_ff[2] <= corners.ur_x * hmy;
         prod_ff[3] <= corners.lr_x * ys;
         prod_ff[4] <= corners.ul_y * wmx;
         prod_ff[5] <= corners.ur_y * xs;
         prod_ff[6] <= corners.ll_y * wmx;
         prod_ff[7] <= corners.lr_y * xs;
         wmx_ff     <= wmx;
         hmy_ff     <= hmy;
         xs_ff      <= xs;
         ys_ff      <= ys;
      end
      // blend along the first axis
      if (stage_ff[0]) begin
         sum_ff[0] <= S_W'(prod_ff[0]) + S_W'(prod_ff[1]);
         sum_ff[1] <= S_W'(prod_ff[2]) + S_W'(prod_ff[3]);
         sum_ff[2] <= S_W'(prod_ff[4]) + S_W'(prod_ff[5]);
         sum_ff[3] <= S_W'(prod_ff[6]) + S_W'(prod_ff[7]);
      end
      // weight along the second axis
      if (stage_ff[1]) begin
         mul_ff[0] <= sum_ff[0] * wmx_ff;
         mul_ff[1] <= sum_ff[1] * xs_ff;
         mul_ff[2] <= sum_ff[2] * hmy_ff;
         mul_ff[3] <= sum_ff[3] * ys_ff;
      end
      if (stage_ff[2]) begin
         num_x_ff <= NUM_W'(mul_ff[0]) + NUM_W'(mul_ff[1]);
         num_y_ff <= NUM_W'(mul_ff[2]) + NUM_W'(mul_ff[3]);
      end
   end

   assign done  = stage_ff[3];
   assign num_x = num_x_ff;
   assign num_y = num_y_ff;

endmodule

/* design/qcfw_div.sv */
`timescale 1ns / 1ps
// Signed division by the frame area, truncating toward zero.
module qcfw_div import qcfw_pkg::*; #(
   parameter int unsigned DEN = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] num,
   output logic                    done,
   output logic signed [NUM_W-1:0] quo
);

   localparam int unsigned SH    = $clog2(DEN);
   localparam bit          POW2  = (DEN & (DEN - 1)) == 0;
   // |num| <= 2^11 * 256 * 256 for every legal frame, so 28 magnitude bits suffice
   localparam int unsigned MAG_W = CRD_W + 16;

   logic                    neg;
   logic [NUM_W-1:0]        mag, qmag;
   logic                    done_ff;
   logic signed [NUM_W-1:0] quo_ff, quo_in;

   assign neg = num[NUM_W-1];
   assign mag = neg ? (~num + NUM_W'(1)) : num;

   if (POW2) begin : g_shift
      assign qmag = mag >> SH;
   end else begin : g_recip
      // floor(mag / DEN) = (mag * ceil(2^(MAG_W+SH) / DEN)) >> (MAG_W+SH) for mag < 2^MAG_W
      localparam int unsigned     RSH   = MAG_W + SH;
      localparam int unsigned     PRD_W = 2 * MAG_W + 1;
      localparam longint unsigned RECIP = ((64'd1 << RSH) + 64'(DEN) - 64'd1) / 64'(DEN);

      logic [PRD_W-1:0] prod;

      assign prod = PRD_W'(mag[MAG_W-1:0]) * PRD_W'(RECIP);
      assign qmag = NUM_W'(prod >> RSH);
   end

   assign quo_in = neg ? -signed'(qmag) : signed'(qmag);

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= quo_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

/* design/quad_corner_forward_warp.sv */
`timescale 1ns / 1ps
// Top level of the quad corner forward warp: control, corner registers, frame memory.
//
// The block keeps an IMG_W x IMG_H frame of 16-bit pixels in one synchronous RAM and
// handles one request word at a time. A clear writes TRANSPARENT_COLOR to every entry,
// one entry a cycle. A place maps (src_x, src_y) onto the quad set by the eight corner
// registers through a four-stage multiply pipeline, divides the numerators by
// IMG_W*IMG_H with truncation toward zero (a shift, or a multiply by a reciprocal
// constant when IMG_W*IMG_H is not a power of two), then writes the pixel if the point
// lands inside the frame and loads the response. A read waits on the RAM's registered
// read. A response word still stalled from the previous request holds the block in its
// done state. Reads of an entry never cleared or written return undefined data; there
// is no clearing pass after reset. Each request gives one response word; the response
// register lets the next request in while a response is still stalled. Write corners
// only while idle.
module quad_corner_forward_warp import qcfw_pkg::*; #(
   parameter int unsigned IMG_W             = 64,
   parameter int unsigned IMG_H             = 64,
   parameter int unsigned TRANSPARENT_COLOR = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_word_type         req_word,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_word_type         rsp_word,
   // corner register write port
   input  logic                 csr_wen,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CRD_W-1:0]     csr_wdata
);

   localparam int unsigned DEPTH = IMG_W * IMG_H;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned XW    = $clog2(IMG_W);
   localparam int unsigned YW    = $clog2(IMG_H);

   localparam logic signed [NUM_W-1:0] CRD_MAX = NUM_W'((2 ** (CRD_W - 1)) - 1);
   localparam logic signed [NUM_W-1:0] CRD_MIN = NUM_W'(-(2 ** (CRD_W - 1)));
   localparam logic signed [NUM_W-1:0] W_LIM   = NUM_W'(IMG_W);
   localparam logic signed [NUM_W-1:0] H_LIM   = NUM_W'(IMG_H);

   // Clamp an exact quotient into the 12-bit coordinate range.
   function automatic logic signed [CRD_W-1:0] sat_crd(input logic signed [NUM_W-1:0] v);
      logic signed [CRD_W-1:0] r;
      if (v > CRD_MAX) begin
         r = CRD_MAX[CRD_W-1:0];
      end else if (v < CRD_MIN) begin
         r = CRD_MIN[CRD_W-1:0];
      end else begin
         r = v[CRD_W-1:0];
      end
      return r;
   endfunction

   state_type    state_ff, state_in;
   req_word_type req_ff, req_in;
   rsp_word_type res_ff, res_in;
   rsp_word_type rsp_word_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_free, rsp_load;
   logic         req_accept;
   logic         rd_ok_ff, rd_ok_in;
   logic [AW-1:0] clr_ptr_ff, clr_ptr_in;
   logic          clr_last;
   corner_type    corner_ff, corner_in;

   // frame memory ports
   logic             ram_we, ram_re;
   logic [AW-1:0]    ram_waddr, ram_raddr;
   logic [PIX_W-1:0] ram_wdata, ram_rdata;

   // mapping and divide
   logic                    map_start, map_done;
   logic signed [NUM_W-1:0] num_x, num_y, quo_x, quo_y;
   logic                    div_x_done, div_y_done, div_done;
   logic                    in_frame;
   logic [AW-1:0]           place_addr;

   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign clr_last   = clr_ptr_ff == AW'(DEPTH - 1);
   assign div_done   = div_x_done && div_y_done;

   assign in_frame = !quo_x[NUM_W-1] && (quo_x < W_LIM) && !quo_y[NUM_W-1] && (quo_y < H_LIM);
   assign place_addr = AW'(AW'(quo_y[YW-1:0]) * AW'(IMG_W)) + AW'(quo_x[XW-1:0]);

   qcfw_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_frame (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   qcfw_map #(
      .IMG_W (IMG_W),
      .IMG_H (IMG_H)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .start   (map_start),
      .src_x   (req_word.src_x),
      .src_y   (req_word.src_y),
      .corners (corner_ff),
      .done    (map_done),
      .num_x   (num_x),
      .num_y   (num_y)
   );

   qcfw_div #(
      .DEN (DEPTH)
   ) u_div_x (
      .clock (clock),
      .reset (reset),
      .start (map_done),
      .num   (num_x),
      .done  (div_x_done),
      .quo   (quo_x)
   );

   qcfw_div #(
      .DEN (DEPTH)
   ) u_div_y (
      .clock (clock),
      .reset (reset),
      .start (map_done),
      .num   (num_y),
      .done  (div_y_done),
      .quo   (quo_y)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_word.req_type)
                  REQ_CLEAR: state_in = ST_CLEAR;
                  REQ_PLACE: state_in = ST_MAP;
                  REQ_READ:  state_in = ST_READ;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_DONE;
            end
         end
         ST_MAP: begin
            if (map_done) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: state_in = ST_DONE;
         ST_READ:  state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath control.
   always_comb begin
      req_stall  = state_ff != ST_IDLE;
      map_start  = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = clr_ptr_ff;
      ram_wdata  = PIX_W'(TRANSPARENT_COLOR);
      ram_re     = 1'b0;
      ram_raddr  = AW'(req_word.read_index);
      clr_ptr_in = clr_ptr_ff;
      req_in     = req_ff;
      res_in     = res_ff;
      rd_ok_in   = rd_ok_ff;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               // latch the word, start from an all-zero response
               req_in     = req_word;
               res_in     = '0;
               clr_ptr_in = '0;
               rd_ok_in   = 32'(req_word.read_index) < DEPTH;
               if (req_word.req_type == REQ_PLACE) begin
                  map_start = 1'b1;
               end
               if (req_word.req_type == REQ_READ) begin
                  ram_re = 1'b1;
               end
            end
         end
         ST_CLEAR: begin
            // sweep every entry, the last one included
            ram_we = 1'b1;
            if (clr_last) begin
               clr_ptr_in = '0;
            end else begin
               clr_ptr_in = clr_ptr_ff + AW'(1);
            end
         end
         ST_WRITE: begin
            res_in.dest_x = sat_crd(quo_x);
            res_in.dest_y = sat_crd(quo_y);
            if (in_frame) begin
               ram_we        = 1'b1;
               ram_waddr     = place_addr;
               ram_wdata     = req_ff.src_pixel;
               res_in.placed = 1'b1;
            end
         end
         ST_READ: begin
            // drop out-of-frame reads to zero
            res_in.read_pixel = rd_ok_ff ? ram_rdata : '0;
         end
         ST_DONE: begin
            rsp_load = rsp_free;
         end
         default: begin
         end
      endcase
   end

   // Corner register writes.
   always_comb begin
      corner_in = corner_ff;
      if (csr_wen) begin
         case (cfg_index_type'(csr_index))
            CFG_UL_X: corner_in.ul_x = csr_wdata;
            CFG_UL_Y: corner_in.ul_y = csr_wdata;
            CFG_UR_X: corner_in.ur_x = csr_wdata;
            CFG_UR_Y: corner_in.ur_y = csr_wdata;
            CFG_LR_X: corner_in.lr_x = csr_wdata;
            CFG_LR_Y: corner_in.lr_y = csr_wdata;
            CFG_LL_X: corner_in.ll_x = csr_wdata;
            CFG_LL_Y: corner_in.ll_y = csr_wdata;
            default:  corner_in = corner_ff;
         endcase
      end
   end

   // Hold the response until taken; advance it as soon as the sink frees up.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         corner_ff    <= CORNER_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         corner_ff    <= corner_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      res_ff   <= res_in;
      rd_ok_ff <= rd_ok_in;
      if (rsp_load) begin
         rsp_word_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
